// File: rtl/vbc_pkg.sv
package vbc_pkg;

   // Largest volume that the counters and the occupancy store are sized for.
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_DEPTH  = 1024;

   // Position counter widths.
   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SLICE_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   // Widths of the clamped dimensions, which can hold the maximum itself.
   localparam int DIMX_W = $clog2(MAX_WIDTH + 1);
   localparam int DIMY_W = $clog2(MAX_HEIGHT + 1);
   localparam int DIMZ_W = $clog2(MAX_DEPTH + 1);

   // Voxels per slice and the backlog between the input and output positions.
   localparam int PLANE_MAX = MAX_WIDTH * MAX_HEIGHT;
   localparam int PLANE_W   = $clog2(PLANE_MAX + 1);
   localparam int PEND_W    = $clog2(PLANE_MAX + 3);

   // The occupancy store is addressed by the running voxel count modulo a
   // power of two. It spans two slices plus room for the jobs still in flight.
   localparam int HIST_SLACK = 64;
   localparam int HIST_AW    = $clog2(2 * PLANE_MAX + HIST_SLACK);
   localparam int HIST_DEPTH = 2 ** HIST_AW;

   // Job queue between the front and the back.
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

   // Field widths of the channels and the register port.
   localparam int SAMPLE_W    = 16;
   localparam int LABEL_W     = 16;
   localparam int POS_X_W     = 8;
   localparam int POS_Y_W     = 8;
   localparam int POS_Z_W     = 10;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_FIELD_W = LABEL_W + POS_X_W + POS_Y_W + POS_Z_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CFG_WIDTH_W  = 9;
   localparam int CFG_HEIGHT_W = 9;
   localparam int CFG_DEPTH_W  = 11;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_WIDTH   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_HEIGHT  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_DEPTH   = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANAR_MODE    = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_LABEL = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERIOR_LABEL = CSR_INDEX_W'(5);

   // Item kinds on the request channel.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   // Reset values of the registers.
   localparam int RESET_WIDTH  = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
   localparam int RESET_HEIGHT = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;
   localparam int RESET_DEPTH  = (1024 > MAX_DEPTH) ? MAX_DEPTH : 1024;
   localparam logic signed [LABEL_W-1:0] RESET_BOUNDARY_LABEL = LABEL_W'(200);
   localparam logic signed [LABEL_W-1:0] RESET_INTERIOR_LABEL = LABEL_W'(100);

   // Neighbour counts of a fully surrounded voxel.
   localparam int NBR_CNT_W = 3;
   localparam logic [NBR_CNT_W-1:0] NEIGHBOURS_3D = NBR_CNT_W'(6);
   localparam logic [NBR_CNT_W-1:0] NEIGHBOURS_2D = NBR_CNT_W'(4);

   // Settings as the datapath sees them.
   typedef struct packed {
      logic [COL_W-1:0]          col_last;
      logic [ROW_W-1:0]          row_last;
      logic [SLICE_W-1:0]        slice_last;
      logic [PLANE_W-1:0]        row_len;
      logic [PLANE_W-1:0]        plane;
      logic                      planar;
      logic signed [LABEL_W-1:0] boundary_label;
      logic signed [LABEL_W-1:0] interior_label;
   } cfg_type;

   // One result to produce: its position, its store address and the end mark.
   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [SLICE_W-1:0] slice;
      logic [HIST_AW-1:0] addr;
      logic               last;
   } job_type;

   // Write into the occupancy store.
   typedef struct packed {
      logic               en;
      logic [HIST_AW-1:0] addr;
      logic               data;
   } hist_wr_type;

   // Neighbour reads from the occupancy store.
   typedef struct packed {
      logic               en;
      logic [HIST_AW-1:0] addr_prev_slice;
      logic [HIST_AW-1:0] addr_next_slice;
      logic [HIST_AW-1:0] addr_prev_row;
      logic [HIST_AW-1:0] addr_next_row;
      logic [HIST_AW-1:0] addr_self;
      logic [HIST_AW-1:0] addr_next_col;
   } hist_rd_type;

   // Registered occupancy bits returned by those reads.
   typedef struct packed {
      logic prev_slice;
      logic next_slice;
      logic prev_row;
      logic next_row;
      logic self;
      logic next_col;
   } hist_data_type;

endpackage

// File: rtl/vbc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module vbc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/vbc_front.sv
// Front end: takes voxels and flush ticks, records occupancy and decides
// when the result of the oldest pending voxel can be released.
module vbc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vbc_pkg::cfg_type                     cfg,
   input  logic                                 restart,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                                 req_kind,
   input  logic signed [vbc_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 queue_full,
   output logic                                 job_push,
   output vbc_pkg::job_type                     job,
   output vbc_pkg::hist_wr_type                 hist_wr
);

   logic [vbc_pkg::COL_W-1:0]   in_col_ff, in_col_in;
   logic [vbc_pkg::ROW_W-1:0]   in_row_ff, in_row_in;
   logic [vbc_pkg::SLICE_W-1:0] in_slice_ff, in_slice_in;
   logic                        in_done_ff, in_done_in;
   logic [vbc_pkg::COL_W-1:0]   out_col_ff, out_col_in;
   logic [vbc_pkg::ROW_W-1:0]   out_row_ff, out_row_in;
   logic [vbc_pkg::SLICE_W-1:0] out_slice_ff, out_slice_in;
   logic [vbc_pkg::HIST_AW-1:0] n_addr_ff, n_addr_in;
   logic [vbc_pkg::HIST_AW-1:0] o_addr_ff, o_addr_in;
   logic [vbc_pkg::PEND_W-1:0]  pending_ff, pending_in;

   logic                       accept;
   logic                       is_sample;
   logic                       active;
   logic                       foreground;
   logic                       do_emit;
   logic                       last_job;
   logic [vbc_pkg::PEND_W-1:0] pend_inc;
   logic [vbc_pkg::PEND_W-1:0] pend_step;
   logic [vbc_pkg::PEND_W-1:0] lag;

   // Transfer and classification of the incoming item.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;
   assign is_sample  = (req_kind == vbc_pkg::KIND_SAMPLE);
   assign active     = is_sample && !in_done_ff;
   assign foreground = !req_sample[vbc_pkg::SAMPLE_W-1] && (req_sample != '0);
   assign pend_inc   = pending_ff + vbc_pkg::PEND_W'(1);
   assign pend_step  = active ? pend_inc : pending_ff;
   assign lag        = cfg.planar ? vbc_pkg::PEND_W'(cfg.row_len)
                                  : vbc_pkg::PEND_W'(cfg.plane);

   // A sample releases a result once the forward neighbour is stored; a flush
   // after the final voxel releases one while any are pending.
   always_comb begin
      if (active) begin
         do_emit = (pend_inc > lag);
      end else begin
         do_emit = !is_sample && in_done_ff && (pending_ff != '0);
      end
   end

   // With all voxels in, a single pending result is the final voxel.
   assign last_job = !is_sample && in_done_ff && (pending_ff == vbc_pkg::PEND_W'(1));

   // Position counters, store addresses and the backlog.
   always_comb begin
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_slice_in  = in_slice_ff;
      in_done_in   = in_done_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_slice_in = out_slice_ff;
      n_addr_in    = n_addr_ff;
      o_addr_in    = o_addr_ff;
      pending_in   = pending_ff;
      if (restart) begin
         in_col_in    = '0;
         in_row_in    = '0;
         in_slice_in  = '0;
         in_done_in   = 1'b0;
         out_col_in   = '0;
         out_row_in   = '0;
         out_slice_in = '0;
         o_addr_in    = n_addr_ff;
         pending_in   = '0;
      end else if (accept) begin
         if (active) begin
            n_addr_in = n_addr_ff + vbc_pkg::HIST_AW'(1);
            if (in_col_ff != cfg.col_last) begin
               in_col_in = in_col_ff + vbc_pkg::COL_W'(1);
            end else begin
               in_col_in = '0;
               if (in_row_ff != cfg.row_last) begin
                  in_row_in = in_row_ff + vbc_pkg::ROW_W'(1);
               end else begin
                  in_row_in = '0;
                  if (in_slice_ff != cfg.slice_last) begin
                     in_slice_in = in_slice_ff + vbc_pkg::SLICE_W'(1);
                  end else begin
                     in_slice_in = '0;
                     in_done_in  = 1'b1;
                  end
               end
            end
         end
         pending_in = pend_step;
         if (do_emit) begin
            o_addr_in = o_addr_ff + vbc_pkg::HIST_AW'(1);
            if (last_job) begin
               out_col_in   = '0;
               out_row_in   = '0;
               out_slice_in = '0;
               in_done_in   = 1'b0;
               pending_in   = '0;
            end else begin
               pending_in = pend_step - vbc_pkg::PEND_W'(1);
               if (out_col_ff != cfg.col_last) begin
                  out_col_in = out_col_ff + vbc_pkg::COL_W'(1);
               end else begin
                  out_col_in = '0;
                  if (out_row_ff != cfg.row_last) begin
                     out_row_in = out_row_ff + vbc_pkg::ROW_W'(1);
                  end else begin
                     out_row_in   = '0;
                     out_slice_in = out_slice_ff + vbc_pkg::SLICE_W'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slice_ff  <= '0;
         in_done_ff   <= 1'b0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slice_ff <= '0;
         n_addr_ff    <= '0;
         o_addr_ff    <= '0;
         pending_ff   <= '0;
      end else begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_slice_ff  <= in_slice_in;
         in_done_ff   <= in_done_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slice_ff <= out_slice_in;
         n_addr_ff    <= n_addr_in;
         o_addr_ff    <= o_addr_in;
         pending_ff   <= pending_in;
      end
   end

   // Job for the back end and the occupancy write.
   assign job_push   = accept && do_emit;
   assign job.col    = out_col_ff;
   assign job.row    = out_row_ff;
   assign job.slice  = out_slice_ff;
   assign job.addr   = o_addr_ff;
   assign job.last   = last_job;

   assign hist_wr.en   = accept && active;
   assign hist_wr.addr = n_addr_ff;
   assign hist_wr.data = foreground;

endmodule

// File: rtl/vbc_job_queue.sv
// Short queue of released jobs between the front and the back.
module vbc_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vbc_pkg::job_type push_job,
   input  logic             pop,
   output vbc_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   vbc_pkg::job_type             entries_ff [vbc_pkg::QUEUE_DEPTH];
   logic [vbc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vbc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vbc_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (vbc_pkg::QUEUE_AW + 1)'(vbc_pkg::QUEUE_DEPTH));
   assign head_job = entries_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + vbc_pkg::QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + vbc_pkg::QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (vbc_pkg::QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (vbc_pkg::QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/vbc_back.sv
// Back end: fetches the neighbours of each released voxel, counts the
// foreground ones and presents the label on the result channel.
module vbc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  vbc_pkg::cfg_type                    cfg,
   input  logic                                q_empty,
   input  vbc_pkg::job_type                    q_head,
   output logic                                q_pop,
   output vbc_pkg::hist_rd_type                hist_rd,
   input  vbc_pkg::hist_data_type              hist_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [vbc_pkg::LABEL_W-1:0]  rsp_label,
   output logic [vbc_pkg::POS_X_W-1:0]         rsp_pos_x,
   output logic [vbc_pkg::POS_Y_W-1:0]         rsp_pos_y,
   output logic [vbc_pkg::POS_Z_W-1:0]         rsp_pos_z,
   output logic                                rsp_is_boundary,
   output logic                                rsp_last
);

   logic                               s1_valid_ff, s1_valid_in;
   vbc_pkg::job_type                   job_ff;
   logic                               prev_occ_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [vbc_pkg::LABEL_W-1:0] label_ff;
   logic [vbc_pkg::POS_X_W-1:0]        pos_x_ff;
   logic [vbc_pkg::POS_Y_W-1:0]        pos_y_ff;
   logic [vbc_pkg::POS_Z_W-1:0]        pos_z_ff;
   logic                               boundary_ff;
   logic                               last_ff;

   logic                               out_free;
   logic                               s1_free;
   logic                               s1_move;
   logic [vbc_pkg::HIST_AW-1:0]        plane_off;
   logic [vbc_pkg::HIST_AW-1:0]        row_off;
   logic [vbc_pkg::NBR_CNT_W-1:0]      cnt;
   logic [vbc_pkg::NBR_CNT_W-1:0]      cnt_full;
   logic signed [vbc_pkg::LABEL_W-1:0] label;
   logic                               boundary;

   // Stall chain: output register, label stage, then the queue head.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign s1_move  = s1_valid_ff && out_free;
   assign q_pop    = !q_empty && s1_free;

   // Neighbour addresses of the job at the queue head.
   assign plane_off               = vbc_pkg::HIST_AW'(cfg.plane);
   assign row_off                 = vbc_pkg::HIST_AW'(cfg.row_len);
   assign hist_rd.en              = q_pop;
   assign hist_rd.addr_prev_slice = q_head.addr - plane_off;
   assign hist_rd.addr_next_slice = q_head.addr + plane_off;
   assign hist_rd.addr_prev_row   = q_head.addr - row_off;
   assign hist_rd.addr_next_row   = q_head.addr + row_off;
   assign hist_rd.addr_self       = q_head.addr;
   assign hist_rd.addr_next_col   = q_head.addr + vbc_pkg::HIST_AW'(1);

   // Count foreground neighbours inside the volume. The left neighbour is the
   // previous voxel, whose occupancy is kept from its own pass.
   always_comb begin
      cnt = '0;
      if (!cfg.planar) begin
         if (job_ff.slice != '0) begin
            cnt = cnt + vbc_pkg::NBR_CNT_W'(hist_data.prev_slice);
         end
         if (job_ff.slice != cfg.slice_last) begin
            cnt = cnt + vbc_pkg::NBR_CNT_W'(hist_data.next_slice);
         end
      end
      if (job_ff.row != '0) begin
         cnt = cnt + vbc_pkg::NBR_CNT_W'(hist_data.prev_row);
      end
      if (job_ff.row != cfg.row_last) begin
         cnt = cnt + vbc_pkg::NBR_CNT_W'(hist_data.next_row);
      end
      if (job_ff.col != '0) begin
         cnt = cnt + vbc_pkg::NBR_CNT_W'(prev_occ_ff);
      end
      if (job_ff.col != cfg.col_last) begin
         cnt = cnt + vbc_pkg::NBR_CNT_W'(hist_data.next_col);
      end
   end

   assign cnt_full = cfg.planar ? vbc_pkg::NEIGHBOURS_2D : vbc_pkg::NEIGHBOURS_3D;

   // Label choice; background voxels take the interior label.
   always_comb begin
      label    = cfg.interior_label;
      boundary = 1'b0;
      if (hist_data.self) begin
         if (cnt == '0) begin
            label = '0;
         end else if (cnt != cnt_full) begin
            label    = cfg.boundary_label;
            boundary = 1'b1;
         end
      end
   end

   // Valid bits of the label stage and the output register.
   always_comb begin
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the label stage and the output register.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end
      if (s1_move) begin
         prev_occ_ff <= hist_data.self;
         label_ff    <= label;
         pos_x_ff    <= vbc_pkg::POS_X_W'(job_ff.col);
         pos_y_ff    <= vbc_pkg::POS_Y_W'(job_ff.row);
         pos_z_ff    <= vbc_pkg::POS_Z_W'(job_ff.slice);
         boundary_ff <= boundary;
         last_ff     <= job_ff.last;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_label       = label_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_is_boundary = boundary_ff;
   assign rsp_last        = last_ff;

endmodule

// File: rtl/volume_boundary_classifier.sv
// Channel  Dir  Handshake               Payload
// req      in   req_tvalid, req_tready  tdata: sample; tuser: kind
// rsp      out  rsp_tvalid, rsp_tready  tdata: label, pos_x, pos_y, pos_z;
//                                       tuser: is_boundary; tlast: last
// csr      in   csr_wr_en               csr_index, csr_wdata
//
// Takes one item per clock unless the job queue is full, and delivers one
// result per clock when released and rsp_tready is high. Results go through
// the job queue, registered reads and label stage into the output; the rate
// is set by the occupancy RAMs, one write and two reads per copy per cycle.
// Reset clears the counters, the job queue and the valid bits; the occupancy
// RAMs are not cleared. req_tready drops only while the job queue is full,
// and a stall on rsp backs up through the label stage into that queue.
module volume_boundary_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vbc_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [15:0] sample
   input  logic                                req_tuser,   // [0] kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vbc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [15:0] label,
                                                            // [23:16] pos_x,
                                                            // [31:24] pos_y,
                                                            // [41:32] pos_z
   output logic                                rsp_tuser,   // [0] is_boundary
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [vbc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [vbc_pkg::DIMX_W-1:0]         width_ff, width_in;
   logic [vbc_pkg::DIMY_W-1:0]         height_ff, height_in;
   logic [vbc_pkg::DIMZ_W-1:0]         depth_ff, depth_in;
   logic [vbc_pkg::PLANE_W-1:0]        plane_ff, plane_in;
   logic                               planar_ff, planar_in;
   logic signed [vbc_pkg::LABEL_W-1:0] boundary_ff, boundary_in;
   logic signed [vbc_pkg::LABEL_W-1:0] interior_ff, interior_in;

   logic [vbc_pkg::CFG_WIDTH_W-1:0]            raw_width;
   logic [vbc_pkg::CFG_HEIGHT_W-1:0]           raw_height;
   logic [vbc_pkg::CFG_DEPTH_W-1:0]            raw_depth;
   logic [vbc_pkg::DIMX_W-1:0]                 new_width;
   logic [vbc_pkg::DIMY_W-1:0]                 new_height;
   logic [vbc_pkg::DIMZ_W-1:0]                 new_depth;
   logic [vbc_pkg::DIMX_W-1:0]                 mul_a;
   logic [vbc_pkg::DIMY_W-1:0]                 mul_b;
   logic [vbc_pkg::DIMX_W+vbc_pkg::DIMY_W-1:0] plane_prod;
   logic                                       dim_write;

   vbc_pkg::cfg_type       cfg;
   vbc_pkg::job_type       push_job;
   vbc_pkg::job_type       head_job;
   vbc_pkg::hist_wr_type   hist_wr;
   vbc_pkg::hist_rd_type   hist_rd;
   vbc_pkg::hist_data_type hist_data;
   logic                   job_push;
   logic                   q_pop;
   logic                   q_empty;
   logic                   q_full;
   logic                   rd_prev_slice, rd_next_slice;
   logic                   rd_prev_row, rd_next_row;
   logic                   rd_self, rd_next_col;

   logic signed [vbc_pkg::LABEL_W-1:0] rsp_label;
   logic [vbc_pkg::POS_X_W-1:0]        rsp_pos_x;
   logic [vbc_pkg::POS_Y_W-1:0]        rsp_pos_y;
   logic [vbc_pkg::POS_Z_W-1:0]        rsp_pos_z;

   // Dimension fields (low bits of csr_wdata) out of range are clamped to 1 and the maximum.
   assign raw_width  = csr_wdata[vbc_pkg::CFG_WIDTH_W-1:0];
   assign raw_height = csr_wdata[vbc_pkg::CFG_HEIGHT_W-1:0];
   assign raw_depth  = csr_wdata[vbc_pkg::CFG_DEPTH_W-1:0];
   assign new_width  = (raw_width == '0) ? vbc_pkg::DIMX_W'(1) :
                       (raw_width > vbc_pkg::MAX_WIDTH) ? vbc_pkg::DIMX_W'(vbc_pkg::MAX_WIDTH) :
                       vbc_pkg::DIMX_W'(raw_width);
   assign new_height = (raw_height == '0) ? vbc_pkg::DIMY_W'(1) :
                       (raw_height > vbc_pkg::MAX_HEIGHT) ?
                       vbc_pkg::DIMY_W'(vbc_pkg::MAX_HEIGHT) : vbc_pkg::DIMY_W'(raw_height);
   assign new_depth  = (raw_depth == '0) ? vbc_pkg::DIMZ_W'(1) :
                       (raw_depth > vbc_pkg::MAX_DEPTH) ? vbc_pkg::DIMZ_W'(vbc_pkg::MAX_DEPTH) :
                       vbc_pkg::DIMZ_W'(raw_depth);

   // Slice size follows the row length and the row count as they are written.
   assign mul_a      = (csr_index == vbc_pkg::CSR_VOLUME_WIDTH) ? new_width : width_ff;
   assign mul_b      = (csr_index == vbc_pkg::CSR_VOLUME_HEIGHT) ? new_height : height_ff;
   assign plane_prod = mul_a * mul_b;

   assign dim_write = csr_wr_en && ((csr_index == vbc_pkg::CSR_VOLUME_WIDTH) ||
                                    (csr_index == vbc_pkg::CSR_VOLUME_HEIGHT) ||
                                    (csr_index == vbc_pkg::CSR_VOLUME_DEPTH));

   // Register writes.
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      depth_in    = depth_ff;
      plane_in    = plane_ff;
      planar_in   = planar_ff;
      boundary_in = boundary_ff;
      interior_in = interior_ff;
      if (csr_wr_en) begin
         case (csr_index)
            vbc_pkg::CSR_VOLUME_WIDTH: begin
               width_in = new_width;
               plane_in = vbc_pkg::PLANE_W'(plane_prod);
            end
            vbc_pkg::CSR_VOLUME_HEIGHT: begin
               height_in = new_height;
               plane_in  = vbc_pkg::PLANE_W'(plane_prod);
            end
            vbc_pkg::CSR_VOLUME_DEPTH: begin
               depth_in = new_depth;
            end
            vbc_pkg::CSR_PLANAR_MODE: begin
               planar_in = csr_wdata[0];
            end
            vbc_pkg::CSR_BOUNDARY_LABEL: begin
               boundary_in = vbc_pkg::LABEL_W'(csr_wdata);
            end
            vbc_pkg::CSR_INTERIOR_LABEL: begin
               interior_in = vbc_pkg::LABEL_W'(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= vbc_pkg::DIMX_W'(vbc_pkg::RESET_WIDTH);
         height_ff   <= vbc_pkg::DIMY_W'(vbc_pkg::RESET_HEIGHT);
         depth_ff    <= vbc_pkg::DIMZ_W'(vbc_pkg::RESET_DEPTH);
         plane_ff    <= vbc_pkg::PLANE_W'(vbc_pkg::RESET_WIDTH * vbc_pkg::RESET_HEIGHT);
         planar_ff   <= 1'b0;
         boundary_ff <= vbc_pkg::RESET_BOUNDARY_LABEL;
         interior_ff <= vbc_pkg::RESET_INTERIOR_LABEL;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_ff    <= depth_in;
         plane_ff    <= plane_in;
         planar_ff   <= planar_in;
         boundary_ff <= boundary_in;
         interior_ff <= interior_in;
      end
   end

   // Settings in the form the datapath uses.
   assign cfg.col_last       = vbc_pkg::COL_W'(width_ff - vbc_pkg::DIMX_W'(1));
   assign cfg.row_last       = vbc_pkg::ROW_W'(height_ff - vbc_pkg::DIMY_W'(1));
   assign cfg.slice_last     = vbc_pkg::SLICE_W'(depth_ff - vbc_pkg::DIMZ_W'(1));
   assign cfg.row_len        = vbc_pkg::PLANE_W'(width_ff);
   assign cfg.plane          = plane_ff;
   assign cfg.planar         = planar_ff;
   assign cfg.boundary_label = boundary_ff;
   assign cfg.interior_label = interior_ff;

   vbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .restart    (dim_write),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_sample (req_tdata[vbc_pkg::SAMPLE_W-1:0]),
      .queue_full (q_full),
      .job_push   (job_push),
      .job        (push_job),
      .hist_wr    (hist_wr)
   );

   vbc_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Three copies of the occupancy store share the write and serve six reads.
   vbc_ram #(
      .WIDTH (1),
      .DEPTH (vbc_pkg::HIST_DEPTH)
   ) u_hist_slice (
      .clock     (clock),
      .wr_en     (hist_wr.en),
      .wr_addr   (hist_wr.addr),
      .wr_data   (hist_wr.data),
      .rd_en     (hist_rd.en),
      .rd_addr_a (hist_rd.addr_prev_slice),
      .rd_addr_b (hist_rd.addr_next_slice),
      .rd_data_a (rd_prev_slice),
      .rd_data_b (rd_next_slice)
   );

   vbc_ram #(
      .WIDTH (1),
      .DEPTH (vbc_pkg::HIST_DEPTH)
   ) u_hist_row (
      .clock     (clock),
      .wr_en     (hist_wr.en),
      .wr_addr   (hist_wr.addr),
      .wr_data   (hist_wr.data),
      .rd_en     (hist_rd.en),
      .rd_addr_a (hist_rd.addr_prev_row),
      .rd_addr_b (hist_rd.addr_next_row),
      .rd_data_a (rd_prev_row),
      .rd_data_b (rd_next_row)
   );

   vbc_ram #(
      .WIDTH (1),
      .DEPTH (vbc_pkg::HIST_DEPTH)
   ) u_hist_col (
      .clock     (clock),
      .wr_en     (hist_wr.en),
      .wr_addr   (hist_wr.addr),
      .wr_data   (hist_wr.data),
      .rd_en     (hist_rd.en),
      .rd_addr_a (hist_rd.addr_self),
      .rd_addr_b (hist_rd.addr_next_col),
      .rd_data_a (rd_self),
      .rd_data_b (rd_next_col)
   );

   always_comb begin
      hist_data.prev_slice = rd_prev_slice;
      hist_data.next_slice = rd_next_slice;
      hist_data.prev_row   = rd_prev_row;
      hist_data.next_row   = rd_next_row;
      hist_data.self       = rd_self;
      hist_data.next_col   = rd_next_col;
   end

   vbc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_empty         (q_empty),
      .q_head          (head_job),
      .q_pop           (q_pop),
      .hist_rd         (hist_rd),
      .hist_data       (hist_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_label       (rsp_label),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_is_boundary (rsp_tuser),
      .rsp_last        (rsp_tlast)
   );

   // Result fields packed from the lowest bit up.
   assign rsp_tdata = {{vbc_pkg::RSP_PAD_W{1'b0}}, rsp_pos_z, rsp_pos_y, rsp_pos_x, rsp_label};

endmodule
